[design/multi_ecu_dtc_clear_sequencer_core_macros.svh]
// Assertion macros for the DTC clear sequencer core.
// Expects clk and arst_n in the scope of each use.
`ifndef MULTI_ECU_DTC_CLEAR_SEQUENCER_CORE_MACROS_SVH
`define MULTI_ECU_DTC_CLEAR_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, off during reset
`define MEDCS_ASSERT_NOW(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, off during reset
`define MEDCS_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

[design/medcs_pkg.sv]
// Package for the DTC clear sequencer: command, phase and register codes,
// ECU address table, frame payloads and progress table. No dependencies.
package medcs_pkg;

	localparam int NUM_ECUS = 14;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_BCAST = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_EXT     = 3'd1;
	localparam logic [2:0] PH_CLEAR   = 3'd2;
	localparam logic [2:0] PH_DEFAULT = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	localparam logic [1:0] REG_STEP_DELAY = 2'd0;
	localparam logic [1:0] REG_BCAST_ID   = 2'd1;
	localparam logic [1:0] REG_CLEAR_MODE = 2'd2;
	localparam logic [1:0] REG_NONE       = 2'd3;

	localparam logic [15:0] STEP_DELAY_RST = 16'd80;
	localparam logic [10:0] BCAST_ID_RST   = 11'h700;
	localparam logic [7:0]  CLEAR_MODE_RST = 8'h04;

	localparam logic [63:0] DATA_EXT     = 64'h0210_0300_0000_0000;
	localparam logic [63:0] DATA_CLEAR   = 64'h0414_FFFF_FF00_0000;
	localparam logic [63:0] DATA_DEFAULT = 64'h0210_0100_0000_0000;

	typedef logic [10:0] ecu_table_t [16];
	typedef logic [6:0]  pct_table_t [16];

	localparam ecu_table_t ECU_TABLE = '{
		11'h7E0, 11'h7E1, 11'h713, 11'h70F, 11'h70E, 11'h710, 11'h712, 11'h714,
		11'h715, 11'h730, 11'h731, 11'h732, 11'h74A, 11'h754, 11'h000, 11'h000
	};

	function automatic pct_table_t build_pct_table();
		pct_table_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = 7'((i * 100) / NUM_ECUS);
		end
		return t;
	endfunction

	localparam pct_table_t PCT_TABLE = build_pct_table();

endpackage

[design/multi_ecu_dtc_clear_sequencer_core.sv]
// An accepted item waits in the command register until the result register can take it.
// Throughput: one item per cycle while res_stall is low; command and result register each hold
// one item, and the phase update plus one 32-bit elapsed-time compare sit between them.
// Reset (arst_n low, asynchronous): run idle, ECU index 0, time stamp 0,
// step delay 80 ms, broadcast id 0x700, clear mode 0x04, both stages empty.
`include "multi_ecu_dtc_clear_sequencer_core_macros.svh"

module multi_ecu_dtc_clear_sequencer_core
	import medcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [31:0] now_ms,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic        frame_valid,
	output logic [10:0] frame_id,
	output logic [63:0] frame_data,
	output logic        start_accepted,
	output logic        busy_res,
	output logic        finished,
	output logic [6:0]  progress_pct,
	output logic [10:0] current_ecu
);

	// config registers
	logic [15:0] step_delay_q;
	logic [10:0] bcast_id_q;
	logic [7:0]  clear_mode_q;
	logic [1:0]  reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_delay_q <= STEP_DELAY_RST;
			bcast_id_q   <= BCAST_ID_RST;
			clear_mode_q <= CLEAR_MODE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STEP_DELAY: step_delay_q <= pwdata[15:0];
				REG_BCAST_ID:   bcast_id_q   <= pwdata[10:0];
				REG_CLEAR_MODE: clear_mode_q <= pwdata[7:0];
				REG_NONE:       ;
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STEP_DELAY: prdata = {16'd0, step_delay_q};
			REG_BCAST_ID:   prdata = {21'd0, bcast_id_q};
			REG_CLEAR_MODE: prdata = {24'd0, clear_mode_q};
			default:        prdata = 32'd0;
		endcase
	end

	// input stage
	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [31:0] now_ms_s1;
	logic        cmd_fire;
	logic        out_free;
	logic        fire_s1;

	assign out_free  = !res_valid || !res_stall;
	assign fire_s1   = valid_s1 && out_free;
	assign cmd_stall = valid_s1 && !out_free;
	assign cmd_fire  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_fire || (valid_s1 && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			command_s1 <= command;
			now_ms_s1  <= now_ms;
		end
	end

	// run state
	logic [2:0]  phase_q;
	logic [3:0]  ecu_idx_q;
	logic [31:0] stamp_q;

	logic [2:0]  phase_d;
	logic [3:0]  ecu_idx_d;
	logic [31:0] stamp_d;
	logic        busy_now;
	logic        busy_d;
	logic        delay_met;
	logic [31:0] elapsed;
	logic        f_valid;
	logic [10:0] f_id;
	logic [63:0] f_data;
	logic        accepted;
	logic [6:0]  pct_d;
	logic [10:0] cur_d;

	assign busy_now  = (phase_q != PH_IDLE) && (phase_q != PH_DONE);
	assign elapsed   = now_ms_s1 - stamp_q;
	assign delay_met = elapsed >= {16'd0, step_delay_q};

	always_comb begin
		phase_d   = phase_q;
		ecu_idx_d = ecu_idx_q;
		stamp_d   = stamp_q;
		f_valid   = 1'b0;
		f_id      = 11'd0;
		f_data    = 64'd0;
		accepted  = 1'b0;
		unique case (command_s1)
			CMD_TICK: begin
				if (busy_now && delay_met) begin
					if (ecu_idx_q >= 4'(NUM_ECUS)) begin
						phase_d = PH_DONE;
					end else begin
						unique case (phase_q)
							PH_EXT: begin
								f_valid = 1'b1;
								f_data  = DATA_EXT;
								phase_d = PH_CLEAR;
							end
							PH_CLEAR: begin
								f_valid = 1'b1;
								f_data  = DATA_CLEAR;
								phase_d = PH_DEFAULT;
							end
							PH_DEFAULT: begin
								f_valid   = 1'b1;
								f_data    = DATA_DEFAULT;
								ecu_idx_d = ecu_idx_q + 4'd1;
								phase_d   = PH_EXT;
							end
							default: phase_d = PH_IDLE;
						endcase
						if (f_valid) begin
							f_id    = ECU_TABLE[ecu_idx_q];
							stamp_d = now_ms_s1;
						end
					end
				end
			end
			CMD_START: begin
				if (!busy_now) begin
					phase_d   = PH_EXT;
					ecu_idx_d = 4'd0;
					stamp_d   = 32'd0;
					accepted  = 1'b1;
				end
			end
			CMD_BCAST: begin
				f_valid = 1'b1;
				f_id    = bcast_id_q;
				f_data  = {8'h01, clear_mode_q, 48'd0};
			end
			CMD_NONE: ;
			default: ;
		endcase
	end

	assign busy_d = (phase_d != PH_IDLE) && (phase_d != PH_DONE);

	always_comb begin
		if (phase_d == PH_IDLE) begin
			pct_d = 7'd0;
		end else if (phase_d == PH_DONE) begin
			pct_d = 7'd100;
		end else begin
			pct_d = PCT_TABLE[ecu_idx_d];
		end
		cur_d = (busy_d && (ecu_idx_d < 4'(NUM_ECUS))) ? ECU_TABLE[ecu_idx_d] : 11'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			ecu_idx_q <= 4'd0;
			stamp_q   <= 32'd0;
		end else if (fire_s1) begin
			phase_q   <= phase_d;
			ecu_idx_q <= ecu_idx_d;
			stamp_q   <= stamp_d;
		end
	end

	// result register
	logic        res_valid_q;
	logic        frame_valid_q;
	logic [10:0] frame_id_q;
	logic [63:0] frame_data_q;
	logic        start_acc_q;
	logic        busy_q;
	logic        finished_q;
	logic [6:0]  pct_q;
	logic [10:0] cur_ecu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= fire_s1 || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			frame_valid_q <= f_valid;
			frame_id_q    <= f_id;
			frame_data_q  <= f_data;
			start_acc_q   <= accepted;
			busy_q        <= busy_d;
			finished_q    <= (phase_d == PH_DONE);
			pct_q         <= pct_d;
			cur_ecu_q     <= cur_d;
		end
	end

	assign res_valid      = res_valid_q;
	assign frame_valid    = frame_valid_q;
	assign frame_id       = frame_id_q;
	assign frame_data     = frame_data_q;
	assign start_accepted = start_acc_q;
	assign busy_res       = busy_q;
	assign finished       = finished_q;
	assign progress_pct   = pct_q;
	assign current_ecu    = cur_ecu_q;

	`MEDCS_ASSERT_NEXT(a_s1_to_result, fire_s1, res_valid, "item left stage 1 but no result")
	`MEDCS_ASSERT_NOW(a_stall_only_full, cmd_stall, valid_s1, "stall with empty command stage")
	`MEDCS_ASSERT_NOW(a_start_state, res_valid && start_accepted,
		busy_res && !finished && progress_pct == 7'd0, "accepted start not reported as a fresh run")
	`MEDCS_ASSERT_NOW(a_done_state, res_valid && finished,
		!busy_res && progress_pct == 7'd100 && current_ecu == 11'd0, "finished run inconsistent")

endmodule
